// ===== rtl/tni_pkg.sv =====
// Shared types and constants for the tensor nonzero-index extractor.
`timescale 1ns / 1ps
`default_nettype none

package tni_pkg;

    localparam int NUM_DIMS     = 6;
    localparam int INDEX_W      = 32;
    localparam int COUNT_OUT_W  = 48;
    localparam int ELEM_W       = 64;
    localparam int IN_TDATA_W   = 2 * ELEM_W;
    localparam int OUT_TDATA_W  = NUM_DIMS * INDEX_W + COUNT_OUT_W;
    localparam int CFG_INDEX_W  = 4;
    localparam int CFG_DATA_W   = 32;
    localparam int QUEUE_DEPTH  = 2;

    localparam int MAX_RANK_DEF    = 6;
    localparam int EXTENT_BITS_DEF = 32;
    localparam int COUNT_BITS_DEF  = 48;

    // register map
    localparam logic [CFG_INDEX_W-1:0] CFG_RANK         = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ELEMENT_TYPE = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXTENT_0     = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_END          = 4'd8;

    // element type codes
    localparam logic [4:0] ET_BOOL = 5'd0;
    localparam logic [4:0] ET_U8   = 5'd1;
    localparam logic [4:0] ET_U16  = 5'd2;
    localparam logic [4:0] ET_U32  = 5'd3;
    localparam logic [4:0] ET_U64  = 5'd4;
    localparam logic [4:0] ET_I8   = 5'd5;
    localparam logic [4:0] ET_I16  = 5'd6;
    localparam logic [4:0] ET_I32  = 5'd7;
    localparam logic [4:0] ET_I64  = 5'd8;
    localparam logic [4:0] ET_F16  = 5'd9;
    localparam logic [4:0] ET_BF16 = 5'd10;
    localparam logic [4:0] ET_F32  = 5'd11;
    localparam logic [4:0] ET_F64  = 5'd12;
    localparam logic [4:0] ET_E4M3 = 5'd13;
    localparam logic [4:0] ET_E5M2 = 5'd14;
    localparam logic [4:0] ET_C32  = 5'd15;
    localparam logic [4:0] ET_C64  = 5'd16;

    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_write_t;

    typedef struct packed {
        logic                                is_nonzero;
        logic [NUM_DIMS-1:0][INDEX_W-1:0]    index;
        logic [COUNT_OUT_W-1:0]              running_count;
        logic                                tensor_end;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/tni_front.sv =====
// Front end: config registers, zero test, coordinate counter and hit count.
`timescale 1ns / 1ps
`default_nettype none

module tni_front #(
    parameter int MAX_RANK    = tni_pkg::MAX_RANK_DEF,
    parameter int EXTENT_BITS = tni_pkg::EXTENT_BITS_DEF,
    parameter int COUNT_BITS  = tni_pkg::COUNT_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tni_pkg::cfg_write_t           cfg_wr,
    input  wire logic                          in_accept,
    input  wire logic [tni_pkg::ELEM_W-1:0]    element_value,
    input  wire logic [tni_pkg::ELEM_W-1:0]    element_imag,
    output logic                               push,
    output tni_pkg::result_t                   push_data
);

    localparam int IW = tni_pkg::INDEX_W;
    localparam int CW = tni_pkg::COUNT_OUT_W;
    localparam int XW = tni_pkg::CFG_INDEX_W;

    localparam logic [15:0] MAG_MASK_16 = 16'h7FFF;
    localparam logic [7:0]  SIGN_FP8    = 8'h80;

    logic [4:0]             elem_type_reg;
    logic [MAX_RANK-1:0]    use_reg;
    logic [EXTENT_BITS-1:0] lim_reg [MAX_RANK];
    logic [EXTENT_BITS-1:0] dig_reg [MAX_RANK];
    logic [EXTENT_BITS-1:0] dig_next [MAX_RANK];
    logic [COUNT_BITS-1:0]  hit_cnt_reg;
    logic [COUNT_BITS-1:0]  hit_cnt_next;
    logic [CW-1:0]          cnt_out;
    logic [EXTENT_BITS-1:0] ext_w;
    logic [MAX_RANK-1:0]    done;
    logic [MAX_RANK-1:0]    carry;
    logic                   last;
    logic                   nz;
    logic                   cfg_hit;
    logic [IW-1:0]          idx [tni_pkg::NUM_DIMS];

    // zero test per element type; float sign bits are ignored
    always_comb
    begin
        unique case (elem_type_reg) inside
            tni_pkg::ET_BOOL, tni_pkg::ET_U8, tni_pkg::ET_I8:
                nz = |element_value[7:0];
            tni_pkg::ET_U16, tni_pkg::ET_I16:
                nz = |element_value[15:0];
            tni_pkg::ET_U32, tni_pkg::ET_I32:
                nz = |element_value[31:0];
            tni_pkg::ET_F16, tni_pkg::ET_BF16:
                nz = |(element_value[15:0] & MAG_MASK_16);
            tni_pkg::ET_F32:
                nz = |element_value[30:0];
            tni_pkg::ET_F64:
                nz = |element_value[62:0];
            tni_pkg::ET_E4M3, tni_pkg::ET_E5M2:
                nz = |(element_value[7:0] & ~SIGN_FP8);
            tni_pkg::ET_C32:
                nz = (|element_value[30:0]) | (|element_value[62:32]);
            tni_pkg::ET_C64:
                nz = (|element_value[62:0]) | (|element_imag[62:0]);
            default:
                nz = |element_value;
        endcase
    end

    // odometer: a dimension steps when every inner dimension sits at its limit
    always_comb
    begin
        logic c;
        c = 1'b1;
        for (int d = MAX_RANK - 1; d >= 0; d--)
        begin
            done[d]  = !use_reg[d] || (dig_reg[d] >= lim_reg[d]);
            carry[d] = c;
            c        = c & done[d];
        end
        last = c;
        for (int d = 0; d < MAX_RANK; d++)
        begin
            if (last)
                dig_next[d] = '0;
            else if (use_reg[d] && carry[d])
                dig_next[d] = done[d] ? '0 : dig_reg[d] + 1'b1;
            else
                dig_next[d] = dig_reg[d];
        end
    end

    assign hit_cnt_next = (nz && !(&hit_cnt_reg)) ? hit_cnt_reg + 1'b1 : hit_cnt_reg;

    generate
        if (COUNT_BITS > CW)
        begin : g_cnt_sat
            assign cnt_out = (|hit_cnt_next[COUNT_BITS-1:CW]) ? '1 : CW'(hit_cnt_next);
        end
        else
        begin : g_cnt_ext
            assign cnt_out = CW'(hit_cnt_next);
        end
    endgenerate

    genvar g;
    generate
        for (g = 0; g < tni_pkg::NUM_DIMS; g++)
        begin : g_idx
            if (g < MAX_RANK)
            begin : g_used
                assign idx[g] = use_reg[g] ? IW'(dig_reg[g]) : '0;
            end
            else
            begin : g_none
                assign idx[g] = '0;
            end
        end
    endgenerate

    always_comb
    begin
        push_data.is_nonzero    = nz;
        for (int d = 0; d < tni_pkg::NUM_DIMS; d++)
            push_data.index[d] = idx[d];
        push_data.running_count = cnt_out;
        push_data.tensor_end    = last;
    end

    assign push    = in_accept && (nz || last);
    assign cfg_hit = cfg_wr.valid && (cfg_wr.index < tni_pkg::CFG_END);
    assign ext_w   = cfg_wr.data[EXTENT_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_type_reg <= tni_pkg::ET_BOOL;
            use_reg       <= MAX_RANK'(1);
            hit_cnt_reg   <= '0;
            for (int d = 0; d < MAX_RANK; d++)
            begin
                lim_reg[d] <= '0;
                dig_reg[d] <= '0;
            end
        end
        else if (cfg_hit)
        begin
            // any register write restarts the tensor
            if (cfg_wr.index == tni_pkg::CFG_RANK)
                for (int d = 0; d < MAX_RANK; d++)
                    use_reg[d] <= int'(cfg_wr.data[2:0]) > d;
            if (cfg_wr.index == tni_pkg::CFG_ELEMENT_TYPE)
                elem_type_reg <= cfg_wr.data[4:0];
            for (int d = 0; d < MAX_RANK; d++)
            begin
                if (cfg_wr.index == XW'(int'(tni_pkg::CFG_EXTENT_0) + d))
                    lim_reg[d] <= (ext_w == '0) ? '0 : ext_w - 1'b1;
                dig_reg[d] <= '0;
            end
            hit_cnt_reg <= '0;
        end
        else if (in_accept)
        begin
            for (int d = 0; d < MAX_RANK; d++)
                dig_reg[d] <= dig_next[d];
            hit_cnt_reg <= last ? '0 : hit_cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tni_queue.sv =====
// Short result queue between the front end and the output stage.
`timescale 1ns / 1ps
`default_nettype none

module tni_queue #(
    parameter int DEPTH = tni_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire tni_pkg::result_t  push_data,
    input  wire logic              pop,
    output logic                   not_empty,
    output logic                   full,
    output tni_pkg::result_t       head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    tni_pkg::result_t mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [NW-1:0]    cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign not_empty = cnt_reg != '0;
    assign full      = cnt_reg == NW'(DEPTH);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tni_back.sv =====
// Output stage: registers one result word and drives the master stream.
`timescale 1ns / 1ps
`default_nettype none

module tni_back (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                q_not_empty,
    input  wire tni_pkg::result_t                    q_head,
    output logic                                     q_pop,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [tni_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    output logic                                     m_axis_tuser,
    output logic                                     m_axis_tlast
);

    logic             out_valid_reg;
    logic             out_valid_next;
    tni_pkg::result_t out_reg;

    assign q_pop = q_not_empty && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        if (q_pop)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            out_reg <= q_head;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.running_count, out_reg.index};
    assign m_axis_tuser  = out_reg.is_nonzero;
    assign m_axis_tlast  = out_reg.tensor_end;

endmodule

`default_nettype wire

// ===== rtl/tensor_nonzero_indices.sv =====
// Nonzero-index extractor over a row-major tensor stream.
//
// s_axis carries one element per word (value and c64 imaginary part). For each
// nonzero element, and for the tensor's last element, one word leaves on
// m_axis with the element's coordinates, the running nonzero count, tuser set
// for a nonzero element and tlast on the tensor's last element.
// Registers are written on the cfg channel (always ready); the user must write
// them only while the stream is idle, which the block itself does not enforce.
// Any write to an index below 8 restarts the coordinate counter and the count.
// Throughput: one element per cycle while the queue is not full, set by the
// combinational zero test and coordinate step in the front end. Each result is
// written to the queue, then moved to the output register that drives m_axis.
// When m_axis stalls, the output register holds its word and a two-entry
// queue absorbs further results; s_axis_tready drops only once that queue is
// full, so elements with no result also wait.
// Reset: rank 1, bool elements, every extent 1, counter and count cleared,
// queue and output empty.
`timescale 1ns / 1ps
`default_nettype none

module tensor_nonzero_indices #(
    parameter int MAX_RANK    = tni_pkg::MAX_RANK_DEF,
    parameter int EXTENT_BITS = tni_pkg::EXTENT_BITS_DEF,
    parameter int COUNT_BITS  = tni_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [tni_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [tni_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // element_value [63:0], element_imag [127:64]
    input  wire logic [tni_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // index_0 [31:0] .. index_5 [191:160], running_count [239:192]
    output logic [tni_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    // is_nonzero [0]
    output logic                                     m_axis_tuser,
    output logic                                     m_axis_tlast
);

    tni_pkg::cfg_write_t cfg_wr;
    tni_pkg::result_t    push_data;
    tni_pkg::result_t    q_head;
    logic                in_accept;
    logic                push;
    logic                q_pop;
    logic                q_not_empty;
    logic                q_full;

    assign cfg_ready     = 1'b1;
    assign cfg_wr.valid  = cfg_valid;
    assign cfg_wr.index  = cfg_index;
    assign cfg_wr.data   = cfg_data;
    assign s_axis_tready = !q_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    tni_front #(
        .MAX_RANK    (MAX_RANK),
        .EXTENT_BITS (EXTENT_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr        (cfg_wr),
        .in_accept     (in_accept),
        .element_value (s_axis_tdata[tni_pkg::ELEM_W-1:0]),
        .element_imag  (s_axis_tdata[tni_pkg::IN_TDATA_W-1:tni_pkg::ELEM_W]),
        .push          (push),
        .push_data     (push_data)
    );

    tni_queue #(
        .DEPTH (tni_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .full      (q_full),
        .head      (q_head)
    );

    tni_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // a full queue only happens behind a stalled output word
    a_full_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> m_axis_tvalid)
        else $error("queue full with output register empty");

    // a word with no hit must be the end-of-tensor report
    a_end_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("zero element reported without tensor end");

    // a hit always carries a count of at least one
    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser
            |-> m_axis_tdata[tni_pkg::OUT_TDATA_W-1:tni_pkg::NUM_DIMS*tni_pkg::INDEX_W] != '0)
        else $error("nonzero element reported with zero count");

endmodule

`default_nettype wire
